### sv/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the RGBA 2x2 box downscaler.
// ----------------------------------------------------------------------------
package rbd_pkg;

	localparam int PIX_W      = 32;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 4;
	localparam int PSUM_CH_W  = 9;
	localparam int QSUM_CH_W  = 10;
	localparam int PSUM_W     = NUM_CH * PSUM_CH_W;
	localparam int CFG_W      = 13;
	localparam int ROW_W      = 12;
	localparam int MAX_HEIGHT = 4096;

	// Register indexes of the configuration port
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Work handed from the front to the back
	typedef enum logic [1:0] {
		OP_PAIR  = 2'd0,  // emit mean of a pixel pair
		OP_WRITE = 2'd1,  // store pair sum in the line buffer
		OP_QUAD  = 2'd2   // emit mean of stored and new pair sums
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic              last;
		logic [PSUM_W-1:0] sum;
	} op_t;

endpackage

### sv/rgba_box_downscale_2x_unit.sv
// ----------------------------------------------------------------------------
// rgba_box_downscale_2x_unit
// 2x2 box-filter downscaler for packed four-channel 8-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Write image_width (index 0) and image_height (index 1) on the cfg
//   channel while the block is idle; each write restarts the frame.
//   Stream pixels in raster order on in_valid/in_ready/in_pixel. Each
//   finished 2x2 block (or pair, for one-pixel-wide or one-pixel-high
//   images) gives one out_pixel, with frame_last on the final one.
//   Pixels of an odd last column or row are consumed and dropped.
// Timing:
//   One pixel is taken every cycle while the queue has room. out_valid
//   rises once the pixel that completes a result has passed through
//   the four-entry queue, the line buffer read stage and then the output
//   register. The line buffer has one write and one read port.
// Reset and stall:
//   Reset sets both sizes to one and clears the position and the queue;
//   the line buffer has no reset; a block mean reads a sum stored a row before.
//   When out_ready is low the output holds, the back stalls, the queue
//   fills and in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module rgba_box_downscale_2x_unit #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [0:0]                 cfg_index,
	input  logic [rbd_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rbd_pkg::PIX_W-1:0]  in_pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rbd_pkg::PIX_W-1:0]  out_pixel,
	output logic                       frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int LD = MAX_WIDTH / 2;
	localparam int AW = (LD > 1) ? $clog2(LD) : 1;
	localparam int QW = AW + $bits(rbd_pkg::op_t);

	logic                 q_full;
	logic                 push;
	rbd_pkg::op_t         push_op;
	logic [AW-1:0]        push_addr;
	logic                 pop;
	logic                 head_valid;
	logic [QW-1:0]        head_data;
	rbd_pkg::op_t         head_op;
	logic [AW-1:0]        head_addr;

	assign head_op   = rbd_pkg::op_t'(head_data[QW-AW-1:0]);
	assign head_addr = head_data[QW-1 -: AW];

	// Position tracking and pairing
	rbd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW),
		.EW        (EW),
		.AW        (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_pixel  (in_pixel),
		.q_full    (q_full),
		.push      (push),
		.push_op   (push_op),
		.push_addr (push_addr)
	);

	// Decouple front and back
	rbd_queue #(
		.W (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_addr, push_op}),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// Line buffer and averaging
	rbd_back #(
		.AW (AW),
		.LD (LD)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.head_addr  (head_addr),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_pixel  (out_pixel),
		.frame_last (frame_last)
	);

endmodule

### sv/rbd_queue.sv
// ----------------------------------------------------------------------------
// rbd_queue
// Four-entry register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module rbd_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output logic [W-1:0] head_data
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [W-1:0]  entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full       = (count_q == (PW+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/rbd_front.sv
// ----------------------------------------------------------------------------
// rbd_front
// Tracks the pixel position, pairs pixels and classifies the work for each
// pixel pair: emit a pair mean, store a pair sum, or emit a block mean.
// ----------------------------------------------------------------------------
module rbd_front #(
	parameter int MAX_WIDTH = 4096,
	parameter int CW        = 12,
	parameter int EW        = 13,
	parameter int AW        = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [0:0]                 cfg_index,
	input  logic [rbd_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rbd_pkg::PIX_W-1:0]  in_pixel,
	input  logic                       q_full,
	output logic                       push,
	output rbd_pkg::op_t               push_op,
	output logic [AW-1:0]              push_addr
);

	logic [EW-1:0]                 width_q;
	logic [rbd_pkg::CFG_W-1:0]     height_q;
	logic [CW-1:0]                 col_q;
	logic [rbd_pkg::ROW_W-1:0]     row_q;
	logic [rbd_pkg::PIX_W-1:0]     held_q;

	logic                          in_xfer;
	logic                          cfg_xfer;
	logic [EW-1:0]                 width_even;
	logic [rbd_pkg::CFG_W-1:0]     height_even;
	logic                          w_one;
	logic                          h_one;
	logic                          col_in;
	logic                          row_in;
	logic                          col_end;
	logic                          row_end;
	logic                          used;
	logic                          odd;
	logic [rbd_pkg::CFG_W-1:0]     cfg_nz;
	logic [EW-1:0]                 width_next;
	logic [rbd_pkg::CFG_W-1:0]     height_next;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign in_ready  = !q_full;
	assign in_xfer   = in_valid && in_ready;

	// Clamp written sizes to their legal ranges
	always_comb begin
		cfg_nz = (cfg_data == '0) ? rbd_pkg::CFG_W'(1) : cfg_data;
		if (32'(cfg_nz) > 32'(MAX_WIDTH)) begin
			width_next = EW'(MAX_WIDTH);
		end else begin
			width_next = EW'(cfg_nz);
		end
		if (32'(cfg_nz) > 32'(rbd_pkg::MAX_HEIGHT)) begin
			height_next = rbd_pkg::CFG_W'(rbd_pkg::MAX_HEIGHT);
		end else begin
			height_next = cfg_nz;
		end
	end

	// Classify the current pixel position
	always_comb begin
		width_even  = {width_q[EW-1:1], 1'b0};
		height_even = {height_q[rbd_pkg::CFG_W-1:1], 1'b0};
		w_one       = (width_q == EW'(1));
		h_one       = (height_q == rbd_pkg::CFG_W'(1));
		col_in      = (EW'(col_q) < width_even);
		row_in      = (rbd_pkg::CFG_W'(row_q) < height_even);
		col_end     = (EW'(col_q) == width_even - EW'(1));
		row_end     = (rbd_pkg::CFG_W'(row_q) == height_even - rbd_pkg::CFG_W'(1));
		used        = 1'b0;
		odd         = 1'b0;
		push_op.kind = rbd_pkg::OP_PAIR;
		push_op.last = 1'b0;
		if (w_one && !h_one) begin
			used         = row_in;
			odd          = row_q[0];
			push_op.last = row_end;
		end else if (h_one && !w_one) begin
			used         = col_in;
			odd          = col_q[0];
			push_op.last = col_end;
		end else if (!w_one && !h_one) begin
			used         = row_in && col_in;
			odd          = col_q[0];
			push_op.kind = row_q[0] ? rbd_pkg::OP_QUAD : rbd_pkg::OP_WRITE;
			push_op.last = row_end && col_end;
		end
		for (int k = 0; k < rbd_pkg::NUM_CH; k++) begin
			push_op.sum[k*rbd_pkg::PSUM_CH_W +: rbd_pkg::PSUM_CH_W] =
				{1'b0, held_q[k*rbd_pkg::CH_W +: rbd_pkg::CH_W]} +
				{1'b0, in_pixel[k*rbd_pkg::CH_W +: rbd_pkg::CH_W]};
		end
		push_addr = AW'(col_q >> 1);
		push      = in_xfer && used && odd;
	end

	// Hold the even pixel of a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (in_xfer && used && !odd) begin
			held_q <= in_pixel;
		end
	end

	// Update sizes and advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= EW'(1);
			height_q <= rbd_pkg::CFG_W'(1);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_xfer) begin
			unique case (rbd_pkg::cfg_reg_t'(cfg_index))
				rbd_pkg::REG_IMAGE_WIDTH:  width_q  <= width_next;
				rbd_pkg::REG_IMAGE_HEIGHT: height_q <= height_next;
				default:                   width_q  <= width_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (EW'(col_q) + EW'(1) >= width_q) begin
				col_q <= '0;
				if (rbd_pkg::CFG_W'(row_q) + rbd_pkg::CFG_W'(1) >= height_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + rbd_pkg::ROW_W'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

### sv/rbd_back.sv
// ----------------------------------------------------------------------------
// rbd_back
// Executes queued work: keeps the line buffer of pair sums, forms the
// averaged pixel and holds it in the output register.
// ----------------------------------------------------------------------------
module rbd_back #(
	parameter int AW = 11,
	parameter int LD = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  rbd_pkg::op_t               head_op,
	input  logic [AW-1:0]              head_addr,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rbd_pkg::PIX_W-1:0]  out_pixel,
	output logic                       frame_last
);

	logic [rbd_pkg::PSUM_W-1:0] line_mem [LD];
	logic [rbd_pkg::PSUM_W-1:0] line_rd_q;

	logic                       valid_s1;
	rbd_pkg::op_t               op_s1;

	logic                       out_valid_q;
	logic [rbd_pkg::PIX_W-1:0]  out_pixel_q;
	logic                       frame_last_q;

	logic                       adv_s1;
	logic                       s1_free;
	logic                       head_wr;
	logic                       take_s1;
	logic [rbd_pkg::PIX_W-1:0]  result;
	logic [rbd_pkg::QSUM_CH_W-1:0] quad;

	assign out_valid  = out_valid_q;
	assign out_pixel  = out_pixel_q;
	assign frame_last = frame_last_q;

	// Pop writes at once, pops that emit need a free stage
	assign adv_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign s1_free = !valid_s1 || adv_s1;
	assign head_wr = (head_op.kind == rbd_pkg::OP_WRITE);
	assign pop     = head_valid && (head_wr || s1_free);
	assign take_s1 = pop && !head_wr;

	// Line buffer write and registered read
	always_ff @(posedge clk) begin
		if (pop && head_wr) begin
			line_mem[head_addr] <= head_op.sum;
		end
		if (take_s1) begin
			line_rd_q <= line_mem[head_addr];
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (take_s1) begin
			op_s1 <= head_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= take_s1;
		end
	end

	// Form the averaged channels
	always_comb begin
		result = '0;
		quad   = '0;
		for (int k = 0; k < rbd_pkg::NUM_CH; k++) begin
			quad = {1'b0, op_s1.sum[k*rbd_pkg::PSUM_CH_W +: rbd_pkg::PSUM_CH_W]} +
				{1'b0, line_rd_q[k*rbd_pkg::PSUM_CH_W +: rbd_pkg::PSUM_CH_W]};
			if (op_s1.kind == rbd_pkg::OP_QUAD) begin
				result[k*rbd_pkg::CH_W +: rbd_pkg::CH_W] = quad[9:2];
			end else begin
				result[k*rbd_pkg::CH_W +: rbd_pkg::CH_W] =
					op_s1.sum[k*rbd_pkg::PSUM_CH_W+1 +: rbd_pkg::CH_W];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_pixel_q  <= result;
			frame_last_q <= op_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
